// ===== rtl/ptd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task dispatcher package
// Shared types, command and action codes and a result helper for the
// dispatcher sequencer and its task update unit.
// ----------------------------------------------------------------------------
package ptd_pkg;

   // Default table depth and the most results one run pass reports.
   localparam int MAX_TASKS_DEFAULT = 16;
   localparam int RESULT_LIMIT      = 16;

   // Command codes.
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_EXEC  = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   // Action codes of a result.
   localparam logic [2:0] ACT_NONE      = 3'd0;
   localparam logic [2:0] ACT_DISPATCH  = 3'd1;
   localparam logic [2:0] ACT_OVERRUN   = 3'd2;
   localparam logic [2:0] ACT_ADDED     = 3'd3;
   localparam logic [2:0] ACT_REJECTED  = 3'd4;
   localparam logic [2:0] ACT_EXEC_DONE = 3'd5;
   localparam logic [2:0] ACT_STATS     = 3'd6;
   localparam logic [2:0] ACT_BAD_INDEX = 3'd7;

   // One row of the task table.
   typedef struct packed {
      logic [30:0] period;
      logic [31:0] last_run;
      logic [31:0] runs;
      logic [31:0] overruns;
      logic [31:0] recent_exec;
      logic [31:0] peak_exec;
   } task_entry_type;

   // Output of the task update unit.
   typedef struct packed {
      logic           due;
      logic [2:0]     action;
      task_entry_type entry;
   } eval_out_type;

   // One result transaction.
   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  slot;
      logic        last;
      logic [30:0] task_period;
      logic [31:0] runs;
      logic [31:0] overruns;
      logic [31:0] recent_exec_us;
      logic [31:0] peak_exec_us;
      logic [4:0]  registered;
   } result_type;

   // Builds a result from a table row; the last flag is set by the caller.
   function automatic result_type make_result(
      input logic [2:0]     action,
      input logic [3:0]     slot,
      input task_entry_type entry,
      input logic [4:0]     registered
   );
      result_type res;
      res.action         = action;
      res.slot           = slot;
      res.last           = 1'b0;
      res.task_period    = entry.period;
      res.runs           = entry.runs;
      res.overruns       = entry.overruns;
      res.recent_exec_us = entry.recent_exec;
      res.peak_exec_us   = entry.peak_exec;
      res.registered     = registered;
      return res;
   endfunction

endpackage

// ===== rtl/ptd_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task update unit
// Shared arithmetic for one table row: due check and advance for a run pass,
// execution time bookkeeping for an exec report, pass-through for a query.
// ----------------------------------------------------------------------------
module ptd_eval (
   input  logic [1:0]              cmd,
   input  ptd_pkg::task_entry_type entry,
   input  logic [31:0]             now_ms,
   input  logic [31:0]             exec_us,
   output ptd_pkg::eval_out_type   result
);
   import ptd_pkg::*;

   logic [31:0] period_ext;
   logic [31:0] twice_period;
   logic [31:0] elapsed;

   // Elapsed time wraps modulo 2^32; twice a 31-bit period always fits.
   assign period_ext   = {1'b0, entry.period};
   assign twice_period = {entry.period, 1'b0};
   assign elapsed      = now_ms - entry.last_run;

   always_comb begin
      result.due    = 1'b0;
      result.action = ACT_STATS;
      result.entry  = entry;
      unique case (cmd)
         CMD_RUN: begin
            // Skip when not due, realign when two periods late, else advance.
            if (elapsed < period_ext) begin
               result.due = 1'b0;
            end else if (elapsed >= twice_period) begin
               result.due            = 1'b1;
               result.action         = ACT_OVERRUN;
               result.entry.overruns = entry.overruns + 32'd1;
               result.entry.last_run = now_ms;
            end else begin
               result.due            = 1'b1;
               result.action         = ACT_DISPATCH;
               result.entry.runs     = entry.runs + 32'd1;
               result.entry.last_run = entry.last_run + period_ext;
            end
         end
         CMD_EXEC: begin
            // Record the latest time and keep the maximum.
            result.due               = 1'b1;
            result.action            = ACT_EXEC_DONE;
            result.entry.recent_exec = exec_us;
            if (exec_us > entry.peak_exec) begin
               result.entry.peak_exec = exec_us;
            end
         end
         default: begin
            result.due    = 1'b1;
            result.action = ACT_STATS;
         end
      endcase
   end

endmodule

// ===== rtl/periodic_task_dispatcher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task dispatcher
// An add or a bad index answers in the cycle after acceptance; an exec
// report or query passes the lookup state before its result is registered.
// A run pass walks the table through one update unit, one task per cycle:
// busy in its run states, results one per cycle at most, never stalled.
// Reset clears the task count and sequencer; table rows are defined by add.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_top #(
   parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_now_ms,
   input  logic [30:0] req_interval_ms,
   input  logic [3:0]  req_task_index,
   input  logic [31:0] req_exec_us,
   output logic        rsp_valid,
   output logic [2:0]  rsp_action,
   output logic [3:0]  rsp_slot,
   output logic        rsp_last,
   output logic [30:0] rsp_task_period,
   output logic [31:0] rsp_runs,
   output logic [31:0] rsp_overruns,
   output logic [31:0] rsp_recent_exec_us,
   output logic [31:0] rsp_peak_exec_us,
   output logic [4:0]  rsp_registered
);
   import ptd_pkg::*;

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int N_W   = $clog2(RESULT_LIMIT + 1);
   localparam int CMP_W = CNT_W + 4;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_LOOKUP  = 2'd1;
   localparam logic [1:0] ST_RUN     = 2'd2;
   localparam logic [1:0] ST_RUN_END = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [31:0]      now_ff, now_in;
   logic [31:0]      exec_ff, exec_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic             pend_valid_ff, pend_valid_in;
   result_type       pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;

   // Task table memory: one write port, one registered read port.
   task_entry_type   table_mem [MAX_TASKS];
   task_entry_type   rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   task_entry_type   wr_data;

   task_entry_type   new_entry;
   eval_out_type     eval_out;
   result_type       cur_res;
   logic             idx_is_last;
   logic             bad_index;
   logic             table_full;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // Shared update unit.
   ptd_eval u_eval (
      .cmd     (cmd_ff),
      .entry   (rd_data_ff),
      .now_ms  (now_ff),
      .exec_us (exec_ff),
      .result  (eval_out)
   );

   assign idx_is_last = (CNT_W'(idx_ff) == (count_ff - CNT_W'(1)));
   assign bad_index   = (CMP_W'(req_task_index) >= CMP_W'(count_ff));
   assign table_full  = (count_ff >= CNT_W'(MAX_TASKS));
   assign cur_res     = make_result(eval_out.action, 4'(idx_ff), eval_out.entry,
                                    5'(count_ff));

   always_comb begin
      new_entry             = '0;
      new_entry.period      = req_interval_ms;
      new_entry.last_run    = req_now_ms;
   end

   // Sequencer and result selection.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      now_in        = now_ff;
      exec_in       = exec_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      rd_addr       = IDX_W'(req_task_index);
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = eval_out.entry;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in  = req_cmd;
               now_in  = req_now_ms;
               exec_in = req_exec_us;
               unique case (req_cmd)
                  CMD_ADD: begin
                     rsp_valid_in = 1'b1;
                     if ((req_interval_ms == 31'd0) || table_full) begin
                        rsp_in = make_result(ACT_REJECTED, 4'd0, '0, 5'(count_ff));
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = IDX_W'(count_ff);
                        wr_data  = new_entry;
                        count_in = count_ff + CNT_W'(1);
                        rsp_in   = make_result(ACT_ADDED, 4'(count_ff), new_entry,
                                               5'(count_in));
                     end
                     rsp_in.last = 1'b1;
                  end
                  CMD_RUN: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_result(ACT_NONE, 4'd0, '0, 5'(count_ff));
                        rsp_in.last  = 1'b1;
                     end else begin
                        rd_addr       = '0;
                        idx_in        = '0;
                        n_in          = '0;
                        pend_valid_in = 1'b0;
                        state_in      = ST_RUN;
                     end
                  end
                  default: begin
                     if (bad_index) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_result(ACT_BAD_INDEX, req_task_index, '0,
                                                   5'(count_ff));
                        rsp_in.last  = 1'b1;
                     end else begin
                        idx_in   = IDX_W'(req_task_index);
                        state_in = ST_LOOKUP;
                     end
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            // Exec report or query on the row read last cycle.
            wr_en        = (cmd_ff == CMD_EXEC);
            rsp_valid_in = 1'b1;
            rsp_in       = cur_res;
            rsp_in.last  = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_RUN: begin
            // Evaluate this row while the next one is read.
            rd_addr = idx_ff + IDX_W'(1);
            idx_in  = idx_ff + IDX_W'(1);
            if (eval_out.due) begin
               wr_en = 1'b1;
               if (n_ff < N_W'(RESULT_LIMIT)) begin
                  // Hold the newest result back until it is known whether it ends the pass.
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                  end
                  pend_in       = cur_res;
                  pend_valid_in = 1'b1;
                  n_in          = n_ff + N_W'(1);
               end
            end
            if (idx_is_last) begin
               state_in = ST_RUN_END;
            end
         end
         ST_RUN_END: begin
            rsp_valid_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_in = pend_ff;
            end else begin
               rsp_in = make_result(ACT_NONE, 4'd0, '0, 5'(count_ff));
            end
            rsp_in.last   = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cmd_ff  <= cmd_in;
      now_ff  <= now_in;
      exec_ff <= exec_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_ff.action;
   assign rsp_slot           = rsp_ff.slot;
   assign rsp_last           = rsp_ff.last;
   assign rsp_task_period    = rsp_ff.task_period;
   assign rsp_runs           = rsp_ff.runs;
   assign rsp_overruns       = rsp_ff.overruns;
   assign rsp_recent_exec_us = rsp_ff.recent_exec_us;
   assign rsp_peak_exec_us   = rsp_ff.peak_exec_us;
   assign rsp_registered     = rsp_ff.registered;

endmodule

// ===== tb/tb_periodic_task_dispatcher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task dispatcher testbench
// Sends add, run pass, exec report and query commands to the dispatcher. A
// local copy of the task table predicts every result transaction, and each
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_periodic_task_dispatcher_top;
   import ptd_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 200000;

   // Clock, reset and the command channel.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = CMD_QUERY;
   logic [31:0] req_now_ms = '0;
   logic [30:0] req_interval_ms = '0;
   logic [3:0]  req_task_index = '0;
   logic [31:0] req_exec_us = '0;

   // Result channel.
   logic        rsp_valid;
   logic [2:0]  rsp_action;
   logic [3:0]  rsp_slot;
   logic        rsp_last;
   logic [30:0] rsp_task_period;
   logic [31:0] rsp_runs;
   logic [31:0] rsp_overruns;
   logic [31:0] rsp_recent_exec_us;
   logic [31:0] rsp_peak_exec_us;
   logic [4:0]  rsp_registered;

   // Local copy of the task table used for prediction.
   logic [30:0] sched_period    [TABLE_DEPTH];
   logic [31:0] sched_last_run  [TABLE_DEPTH];
   logic [31:0] sched_runs      [TABLE_DEPTH];
   logic [31:0] sched_overruns  [TABLE_DEPTH];
   logic [31:0] sched_recent    [TABLE_DEPTH];
   logic [31:0] sched_peak      [TABLE_DEPTH];
   logic [4:0]  sched_count = '0;

   // Predicted result transactions in order of arrival.
   result_type  awaited_reports [$];

   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   logic [31:0] tick_ms = '0;

   periodic_task_dispatcher_top uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_now_ms         (req_now_ms),
      .req_interval_ms    (req_interval_ms),
      .req_task_index     (req_task_index),
      .req_exec_us        (req_exec_us),
      .rsp_valid          (rsp_valid),
      .rsp_action         (rsp_action),
      .rsp_slot           (rsp_slot),
      .rsp_last           (rsp_last),
      .rsp_task_period    (rsp_task_period),
      .rsp_runs           (rsp_runs),
      .rsp_overruns       (rsp_overruns),
      .rsp_recent_exec_us (rsp_recent_exec_us),
      .rsp_peak_exec_us   (rsp_peak_exec_us),
      .rsp_registered     (rsp_registered)
   );

   // Free-running clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Builds a result from the local table; rejects and misses carry no statistics.
   function automatic result_type task_report(input logic [2:0] action,
                                              input logic [3:0] slot,
                                              input bit with_stats);
      result_type rep;
      rep = '0;
      rep.action = action;
      rep.slot = slot;
      rep.registered = sched_count;
      if (with_stats) begin
         rep.task_period    = sched_period[slot];
         rep.runs           = sched_runs[slot];
         rep.overruns       = sched_overruns[slot];
         rep.recent_exec_us = sched_recent[slot];
         rep.peak_exec_us   = sched_peak[slot];
      end
      return rep;
   endfunction

   // Applies one accepted command to the local table and queues its results.
   task automatic advance_schedule(input logic [1:0] cmd, input logic [31:0] now_ms,
                                   input logic [30:0] interval_ms,
                                   input logic [3:0] task_sel,
                                   input logic [31:0] exec_us);
      result_type  batch [$];
      result_type  tail;
      logic [31:0] elapsed;
      logic [3:0]  slot;
      case (cmd)
         CMD_ADD: begin
            if (interval_ms == '0 || sched_count >= TABLE_DEPTH) begin
               batch.push_back(task_report(ACT_REJECTED, 4'd0, 1'b0));
            end else begin
               slot = sched_count[3:0];
               sched_period[slot]   = interval_ms;
               sched_last_run[slot] = now_ms;
               sched_runs[slot]     = '0;
               sched_overruns[slot] = '0;
               sched_recent[slot]   = '0;
               sched_peak[slot]     = '0;
               sched_count = sched_count + 5'd1;
               batch.push_back(task_report(ACT_ADDED, slot, 1'b1));
            end
         end
         CMD_RUN: begin
            // Visit registered tasks in index order at a single time value.
            for (int i = 0; i < sched_count; i++) begin
               elapsed = now_ms - sched_last_run[i];
               if (elapsed >= {1'b0, sched_period[i]}) begin
                  if (elapsed >= {sched_period[i], 1'b0}) begin
                     sched_overruns[i] = sched_overruns[i] + 32'd1;
                     sched_last_run[i] = now_ms;
                     if (batch.size() < RESULT_LIMIT) begin
                        batch.push_back(task_report(ACT_OVERRUN, i[3:0], 1'b1));
                     end
                  end else begin
                     sched_last_run[i] = sched_last_run[i] + {1'b0, sched_period[i]};
                     sched_runs[i] = sched_runs[i] + 32'd1;
                     if (batch.size() < RESULT_LIMIT) begin
                        batch.push_back(task_report(ACT_DISPATCH, i[3:0], 1'b1));
                     end
                  end
               end
            end
            if (batch.size() == 0) begin
               batch.push_back(task_report(ACT_NONE, 4'd0, 1'b0));
            end
         end
         default: begin
            if ({1'b0, task_sel} >= sched_count) begin
               batch.push_back(task_report(ACT_BAD_INDEX, task_sel, 1'b0));
            end else if (cmd == CMD_EXEC) begin
               sched_recent[task_sel] = exec_us;
               if (exec_us > sched_peak[task_sel]) begin
                  sched_peak[task_sel] = exec_us;
               end
               batch.push_back(task_report(ACT_EXEC_DONE, task_sel, 1'b1));
            end else begin
               batch.push_back(task_report(ACT_STATS, task_sel, 1'b1));
            end
         end
      endcase
      // The final result of the transaction carries the last flag.
      tail = batch.pop_back();
      tail.last = 1'b1;
      batch.push_back(tail);
      foreach (batch[k]) begin
         awaited_reports.push_back(batch[k]);
      end
   endtask

   // Sends one command transaction, with bursts and random gaps between them.
   task automatic issue_command(input logic [1:0] cmd, input logic [31:0] now_ms,
                                input logic [30:0] interval_ms,
                                input logic [3:0] task_sel,
                                input logic [31:0] exec_us);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start = 1'b1;
      req_cmd = cmd;
      req_now_ms = now_ms;
      req_interval_ms = interval_ms;
      req_task_index = task_sel;
      req_exec_us = exec_us;
      do @(posedge clock); while (busy);
      advance_schedule(cmd, now_ms, interval_ms, task_sel, exec_us);
   endtask

   // Stops sending and waits for every predicted result plus a margin.
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void check_field(input string what, input logic [31:0] want_val,
                                       input logic [31:0] got_val);
      if (got_val !== want_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, what, want_val, got_val);
         mismatch_count++;
      end
   endfunction

   // Every result transaction is compared with the oldest prediction.
   always @(posedge clock) begin : report_checker
      result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual action %0d slot %0d",
                     $time, rsp_action, rsp_slot);
            mismatch_count++;
         end else begin
            want = awaited_reports.pop_front();
            check_field("action", 32'(want.action), 32'(rsp_action));
            check_field("slot", 32'(want.slot), 32'(rsp_slot));
            check_field("last", 32'(want.last), 32'(rsp_last));
            check_field("task_period", 32'(want.task_period), 32'(rsp_task_period));
            check_field("runs", want.runs, rsp_runs);
            check_field("overruns", want.overruns, rsp_overruns);
            check_field("recent_exec_us", want.recent_exec_us, rsp_recent_exec_us);
            check_field("peak_exec_us", want.peak_exec_us, rsp_peak_exec_us);
            check_field("registered", 32'(want.registered), 32'(rsp_registered));
         end
      end
   end

   // Commands against an empty table: misses and a pass with nothing due.
   task automatic test_empty_table();
      issue_command(CMD_QUERY, 32'd0, 31'd0, 4'd0, 32'd0);
      issue_command(CMD_EXEC, 32'd0, 31'd0, 4'hF, 32'hFFFF_FFFF);
      issue_command(CMD_RUN, 32'hFFFF_FFFF, 31'd0, 4'd0, 32'd0);
   endtask

   // Zero period is rejected; shortest and longest periods are accepted.
   task automatic test_add_rules();
      issue_command(CMD_ADD, 32'h1234_5678, 31'd0, 4'd0, 32'd0);
      issue_command(CMD_ADD, 32'hFFFF_FFF0, 31'd1, 4'd0, 32'd0);
      issue_command(CMD_ADD, 32'h0000_0000, 31'h7FFF_FFFF, 4'd0, 32'd0);
      issue_command(CMD_ADD, 32'hFFFF_FFF8, 31'd10, 4'd0, 32'd0);
   endtask

   // Run passes across the time wrap and on both due boundaries.
   task automatic test_run_pass_timing();
      issue_command(CMD_RUN, 32'hFFFF_FFF0, 31'd0, 4'd0, 32'd0);
      issue_command(CMD_RUN, 32'hFFFF_FFF1, 31'd0, 4'd0, 32'd0);
      issue_command(CMD_RUN, 32'hFFFF_FFFA, 31'd0, 4'd0, 32'd0);
      issue_command(CMD_RUN, 32'h0000_0003, 31'd0, 4'd0, 32'd0);
      issue_command(CMD_RUN, 32'h0000_0004, 31'd0, 4'd0, 32'd0);
      issue_command(CMD_RUN, 32'h0000_0004, 31'd0, 4'd0, 32'd0);
      // Longest period not yet due, while the shorter periods overrun.
      issue_command(CMD_RUN, 32'h7FFF_FFEF, 31'd0, 4'd0, 32'd0);
      // Just under two periods dispatches; exactly two periods is an overrun.
      issue_command(CMD_RUN, 32'h8000_0002, 31'd0, 4'd0, 32'd0);
      issue_command(CMD_RUN, 32'h8000_000D, 31'd0, 4'd0, 32'd0);
   endtask

   // Execution-time statistics and queries, including out-of-range indexes.
   task automatic test_exec_and_query();
      issue_command(CMD_EXEC, 32'd0, 31'd0, 4'd0, 32'hFFFF_FFFF);
      issue_command(CMD_EXEC, 32'd0, 31'd0, 4'd0, 32'd5);
      issue_command(CMD_EXEC, 32'd0, 31'd0, 4'd1, 32'd0);
      issue_command(CMD_QUERY, 32'd0, 31'd0, 4'd2, 32'd0);
      issue_command(CMD_EXEC, 32'd0, 31'd0, 4'd3, 32'h0000_0042);
      issue_command(CMD_QUERY, 32'd0, 31'd0, 4'hF, 32'd0);
   endtask

   // Run passes on an advancing tick, the most common command, mixed with adds, reports and queries.
   task automatic test_random_traffic();
      int          pick;
      logic [1:0]  cmd;
      logic [31:0] now_ms;
      logic [30:0] interval_ms;
      logic [3:0]  task_sel;
      logic [31:0] exec_us;
      tick_ms = 32'hFFFF_F800;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         now_ms = $urandom();
         interval_ms = 31'($urandom());
         task_sel = 4'($urandom());
         exec_us = $urandom();
         if (pick < ((sched_count < TABLE_DEPTH) ? 20 : 8)) begin
            cmd = CMD_ADD;
            now_ms = tick_ms;
            // While the table has room, favor short periods that fall due often.
            if (sched_count < TABLE_DEPTH) begin
               case ($urandom_range(0, 9))
                  0: interval_ms = '0;
                  1: interval_ms = 31'($urandom_range(1, 32'h7FFF_FFFF));
                  default: interval_ms = 31'($urandom_range(1, 48));
               endcase
            end
         end else if (pick < 60) begin
            cmd = CMD_RUN;
            case ($urandom_range(0, 19))
               0: tick_ms = $urandom();
               1, 2: tick_ms = tick_ms + $urandom_range(25, 600);
               default: tick_ms = tick_ms + $urandom_range(0, 24);
            endcase
            now_ms = tick_ms;
         end else begin
            cmd = (pick < 80) ? CMD_EXEC : CMD_QUERY;
            if (sched_count != 0 && $urandom_range(0, 5) != 0) begin
               task_sel = 4'($urandom_range(0, sched_count - 1));
            end
            if ($urandom_range(0, 1) == 0) begin
               exec_us = $urandom_range(0, 5000);
            end
         end
         issue_command(cmd, now_ms, interval_ms, task_sel, exec_us);
      end
   endtask

   // Fill the table, then an add is rejected and a pass covers every slot.
   task automatic test_table_full();
      while (sched_count < TABLE_DEPTH) begin
         issue_command(CMD_ADD, tick_ms, 31'($urandom_range(1, 30)), 4'd0, 32'd0);
      end
      issue_command(CMD_ADD, tick_ms, 31'd5, 4'd0, 32'd0);
      issue_command(CMD_QUERY, tick_ms, 31'd0, 4'hF, 32'd0);
      tick_ms = tick_ms + 32'd45;
      issue_command(CMD_RUN, tick_ms, 31'd0, 4'd0, 32'd0);
   endtask

   // Cycle counter that ends a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_periodic_task_dispatcher_top: done, errors");
      $finish;
   end

   // Test sequence.
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_table();
      test_add_rules();
      test_run_pass_timing();
      test_exec_and_query();
      test_random_traffic();
      test_table_full();
      settle();
      if (mismatch_count == 0) begin
         $display("tb_periodic_task_dispatcher_top: done, clean");
      end else begin
         $display("tb_periodic_task_dispatcher_top: done, errors");
      end
      $finish;
   end

endmodule
